// ===== rtl/md5_pkg.sv =====
// Shared types, constants and a rotate helper function for the MD5 digest block.
package md5_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [31:0] PAD_MARK = 32'h00000080;

  localparam logic [31:0] SINE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_byte;
  } msg_req_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } digest_req_t;

  typedef struct packed {
    logic [15:0][31:0] words;
    logic              fin;
  } job_t;

  typedef struct packed {
    logic              load;
    logic [3:0][31:0]  words;
  } emit_load_t;

  typedef enum logic [1:0] {
    F_IN,
    F_FULL,
    F_PAD,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_ADD
  } back_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

// ===== rtl/md5_front.sv =====
// Front end: packs message bytes into 64-byte blocks and builds the padded final blocks.
module md5_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  md5_pkg::msg_req_t msg,
  output logic              push,
  output md5_pkg::job_t     job,
  input  logic              full
);

  md5_pkg::front_state_t state, state_next;
  logic [60:0]           count;
  logic                  pend_last;
  logic [15:0][31:0]     blk;
  logic [15:0][31:0]     pad_words;
  logic [15:0][31:0]     len_words;
  logic [5:0]            pos;
  logic [3:0]            wi;
  logic [4:0]            sh;
  logic [63:0]           len_bits;
  logic                  acc;
  logic                  short_pad;

  assign pos       = count[5:0];
  assign wi        = pos[5:2];
  assign sh        = {pos[1:0], 3'b000};
  assign len_bits  = {count, 3'b000};
  assign short_pad = (pos[5:3] != 3'b111);
  assign acc       = msg_valid && !msg_stall;

  always_comb begin
    for (int w = 0; w < 16; w++) begin
      if (4'(w) < wi) begin
        pad_words[w] = blk[w];
      end else if (4'(w) == wi) begin
        pad_words[w] = (pos[1:0] == 2'd0) ? md5_pkg::PAD_MARK
                                          : (blk[w] | (md5_pkg::PAD_MARK << sh));
      end else begin
        pad_words[w] = '0;
      end
    end
    if (short_pad) begin
      pad_words[14] = len_bits[31:0];
      pad_words[15] = len_bits[63:32];
    end
    len_words     = '0;
    len_words[14] = len_bits[31:0];
    len_words[15] = len_bits[63:32];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::F_IN: begin
        if (acc) begin
          if (!msg.no_byte && pos == 6'd63) begin
            state_next = md5_pkg::F_FULL;
          end else if (msg.last_byte) begin
            state_next = md5_pkg::F_PAD;
          end
        end
      end
      md5_pkg::F_FULL: begin
        if (!full) begin
          state_next = pend_last ? md5_pkg::F_PAD : md5_pkg::F_IN;
        end
      end
      md5_pkg::F_PAD: begin
        if (!full) begin
          state_next = short_pad ? md5_pkg::F_IN : md5_pkg::F_LEN;
        end
      end
      md5_pkg::F_LEN: begin
        if (!full) begin
          state_next = md5_pkg::F_IN;
        end
      end
      default: state_next = md5_pkg::F_IN;
    endcase
  end

  always_comb begin
    msg_stall = (state != md5_pkg::F_IN);
    push      = 1'b0;
    job.words = blk;
    job.fin   = 1'b0;
    unique case (state)
      md5_pkg::F_IN: begin
        push = 1'b0;
      end
      md5_pkg::F_FULL: begin
        push = 1'b1;
      end
      md5_pkg::F_PAD: begin
        push      = 1'b1;
        job.words = pad_words;
        job.fin   = short_pad;
      end
      md5_pkg::F_LEN: begin
        push      = 1'b1;
        job.words = len_words;
        job.fin   = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= md5_pkg::F_IN;
      count     <= '0;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        pend_last <= msg.last_byte;
      end
      if (acc && !msg.no_byte) begin
        count <= count + 61'd1;
      end else if (push && !full && job.fin) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !msg.no_byte) begin
      if (pos[1:0] == 2'd0) begin
        blk[wi] <= {24'd0, msg.data_byte};
      end else begin
        blk[wi][sh +: 8] <= msg.data_byte;
      end
    end
  end

  // a full block is handed over right after its 64th byte, so the count is block aligned
  a_full_aligned: assert property (@(posedge clk) disable iff (rst)
    state == md5_pkg::F_FULL |-> pos == 6'd0)
    else $error("front: full block pending at unaligned count");

endmodule

// ===== rtl/md5_queue.sv =====
// Block queue between the front end and the compression engine.
module md5_queue #(
  parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  md5_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output md5_pkg::job_t head_job,
  output logic          avail
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  md5_pkg::job_t   entries [DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CW-1:0]   cnt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt == CW'(DEPTH));
  assign avail    = (cnt != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;
  assign head_job = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_job;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("queue: pop while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("queue: occupancy beyond depth");

endmodule

// ===== rtl/md5_back.sv =====
// Compression engine: 64 MD5 rounds, one per cycle, on the queued block.
module md5_back (
  input  logic                clk,
  input  logic                rst,
  input  md5_pkg::job_t       head_job,
  input  logic                avail,
  output logic                pop,
  output md5_pkg::emit_load_t emit,
  input  logic                emit_busy
);

  md5_pkg::back_state_t state, state_next;
  logic [3:0][31:0]     chain;
  logic [31:0]          a, b, c, d;
  logic [5:0]           rnd;
  logic [31:0]          f;
  logic [3:0]           g;
  logic [31:0]          mix;
  logic [31:0]          nb;
  logic [3:0][31:0]     sums;
  logic                 go;

  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = rnd[3:0];
      end
      2'd1: begin
        f = (d & b) | (~d & c);
        g = 4'(rnd[3:0] * 5 + 1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = 4'(rnd[3:0] * 3 + 5);
      end
      2'd3: begin
        f = c ^ (b | ~d);
        g = 4'(rnd[3:0] * 7);
      end
      default: begin
        f = '0;
        g = '0;
      end
    endcase
    mix = a + f + md5_pkg::SINE[rnd] + head_job.words[g];
    nb  = b + md5_pkg::rotl32(mix, md5_pkg::ROT[{rnd[5:4], rnd[1:0]}]);
  end

  assign sums[0] = chain[0] + a;
  assign sums[1] = chain[1] + b;
  assign sums[2] = chain[2] + c;
  assign sums[3] = chain[3] + d;
  assign go      = !head_job.fin || !emit_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::B_IDLE:  if (avail) state_next = md5_pkg::B_ROUND;
      md5_pkg::B_ROUND: if (rnd == 6'd63) state_next = md5_pkg::B_ADD;
      md5_pkg::B_ADD:   if (go) state_next = md5_pkg::B_IDLE;
      default: state_next = md5_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == md5_pkg::B_ADD) && go;
    emit.load  = pop && head_job.fin;
    emit.words = sums;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5_pkg::B_IDLE;
      chain <= {md5_pkg::IV3, md5_pkg::IV2, md5_pkg::IV1, md5_pkg::IV0};
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (state == md5_pkg::B_IDLE) begin
        rnd <= '0;
      end else if (state == md5_pkg::B_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (pop) begin
        chain <= head_job.fin ? {md5_pkg::IV3, md5_pkg::IV2, md5_pkg::IV1, md5_pkg::IV0}
                              : sums;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == md5_pkg::B_IDLE) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (state == md5_pkg::B_ROUND) begin
      a <= d;
      b <= nb;
      c <= b;
      d <= c;
    end
  end

  a_add_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::B_ROUND && rnd == 6'd63) |=> state == md5_pkg::B_ADD)
    else $error("back: round count did not end the block");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    emit.load |-> !emit_busy)
    else $error("back: digest loaded over a pending digest");

endmodule

// ===== rtl/md5_emit.sv =====
// Output stage: holds one digest and sends it out a byte per request.
module md5_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  md5_pkg::emit_load_t  emit,
  output logic                 busy,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output md5_pkg::digest_req_t digest
);

  logic [127:0] sh;
  logic [3:0]   cnt;
  logic         take;

  assign digest_valid       = busy;
  assign take               = busy && !digest_stall;
  assign digest.digest_byte = sh[7:0];
  assign digest.digest_last = (cnt == 4'hf);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (emit.load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (take) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'hf) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      sh <= emit.words;
    end else if (take) begin
      sh <= {8'd0, sh[127:8]};
    end
  end

endmodule

// ===== rtl/md5_message_digest.sv =====
// Top level of the MD5 digest block: front end, block queue, round engine, output stage.
//
// Input channel msg: one request per message byte (data_byte), last_byte on the
// final request; no_byte marks a request without a byte, used to end an empty
// message. Output channel digest: 16 requests per message, h0 low byte first
// through h3 high byte, digest_last on the sixteenth.
// Bytes are taken one per cycle while the front end is collecting; it pauses to hand
// each full block to the queue, and at message end to build the padded block(s),
// and waits while the queue is full. The queue holds QUEUE_DEPTH blocks.
// The round engine works through each 64-byte block (load, 64 rounds, add) before
// taking the next, so long messages are paced by the round engine.
// How soon the digest appears after the last request depends on whether padding
// needs one block or two, and on any queued work ahead of it.
// Reset clears all control state and loads the initial chaining values; the
// block is ready the cycle after reset drops.
// A stall on digest holds the current byte; the engine keeps working on queued
// blocks and waits only when a further digest is complete while one is pending.
module md5_message_digest #(
  parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  output logic                 msg_stall,
  input  md5_pkg::msg_req_t    msg,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output md5_pkg::digest_req_t digest
);

  logic                push;
  md5_pkg::job_t       push_job;
  logic                full;
  logic                pop;
  md5_pkg::job_t       head_job;
  logic                avail;
  md5_pkg::emit_load_t emit;
  logic                emit_busy;

  md5_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .push      (push),
    .job       (push_job),
    .full      (full)
  );

  md5_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .avail    (avail)
  );

  md5_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .avail     (avail),
    .pop       (pop),
    .emit      (emit),
    .emit_busy (emit_busy)
  );

  md5_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .busy         (emit_busy),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

// ===== sim/md5_digest_checker.sv =====
// Digest checker: predicts MD5 digest bytes from accepted message requests and compares.
`timescale 1ns / 100ps

module md5_digest_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  input  logic                 msg_stall,
  input  md5_pkg::msg_req_t    msg,
  input  logic                 digest_valid,
  input  logic                 digest_stall,
  input  md5_pkg::digest_req_t digest,
  output int                   fail_count,
  output int                   pending
);

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam int PRINT_CAP = 100;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0] chain_w [4];
  logic [31:0] block_w [16];
  logic [60:0] byte_total;
  md5_pkg::digest_req_t digest_expected_q [$];

  function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic load_init();
    chain_w[0] = INIT_A;
    chain_w[1] = INIT_B;
    chain_w[2] = INIT_C;
    chain_w[3] = INIT_D;
    byte_total = '0;
  endtask

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int i, g;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d);
        g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c);
        g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d;
        g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d);
        g = (7 * i) % 16;
      end
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + ROUND_K[i] + block_w[g], SHIFTS[(i / 16) * 4 + i % 4]);
      a = t;
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
  endtask

  // first byte of a word clears the rest of it
  task automatic absorb_byte(input logic [5:0] pos, input logic [7:0] v);
    if (pos[1:0] == 2'd0) begin
      block_w[pos[5:2]] = {24'h0, v};
    end else begin
      block_w[pos[5:2]][8 * pos[1:0] +: 8] = v;
    end
  endtask

  task automatic take_request(input md5_pkg::msg_req_t req);
    logic [5:0] pos;
    logic [63:0] bit_len;
    md5_pkg::digest_req_t e;
    int i;
    if (!req.no_byte) begin
      pos = byte_total[5:0];
      absorb_byte(pos, req.data_byte);
      byte_total = byte_total + 61'd1;
      if (pos == 6'd63) md5_compress();
    end
    if (req.last_byte) begin
      pos = byte_total[5:0];
      absorb_byte(pos, 8'h80);
      for (i = int'(pos[5:2]) + 1; i < 16; i++) block_w[i] = '0;
      // no room left for the length: it goes in an extra block
      if (pos >= 6'd56) begin
        md5_compress();
        for (i = 0; i < 16; i++) block_w[i] = '0;
      end
      bit_len = {byte_total, 3'b000};
      block_w[14] = bit_len[31:0];
      block_w[15] = bit_len[63:32];
      md5_compress();
      for (i = 0; i < 16; i++) begin
        e.digest_byte = chain_w[i / 4][8 * (i % 4) +: 8];
        e.digest_last = (i == 15);
        digest_expected_q.push_back(e);
      end
      load_init();
    end
  endtask

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("%0t ns: digest mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_digest(input md5_pkg::digest_req_t got);
    md5_pkg::digest_req_t exp;
    if (digest_expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected request byte %02h last %0b",
                                got.digest_byte, got.digest_last));
    end else begin
      exp = digest_expected_q.pop_front();
      if (got.digest_byte !== exp.digest_byte)
        report_mismatch($sformatf("digest_byte got %02h expected %02h",
                                  got.digest_byte, exp.digest_byte));
      if (got.digest_last !== exp.digest_last)
        report_mismatch($sformatf("digest_last got %0b expected %0b",
                                  got.digest_last, exp.digest_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      load_init();
      for (int i = 0; i < 16; i++) block_w[i] = '0;
      digest_expected_q.delete();
    end else begin
      if (msg_valid && !msg_stall) take_request(msg);
      if (digest_valid && !digest_stall) check_digest(digest);
    end
    pending = digest_expected_q.size();
  end

endmodule

// ===== sim/tb_md5_message_digest.sv =====
// Testbench top for md5_message_digest: message stimulus, digest back-pressure, verdict.
`timescale 1ns / 100ps

module tb_md5_message_digest;

  localparam int RANDOM_ITEMS = 350;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  logic                 clk;
  logic                 rst;
  logic                 msg_valid;
  logic                 msg_stall;
  md5_pkg::msg_req_t    msg;
  logic                 digest_valid;
  logic                 digest_stall;
  md5_pkg::digest_req_t digest;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles;
  int                   item_total;
  bit                   msg_burst;
  bit                   digest_burst;

  localparam int EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  md5_message_digest i_dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  md5_digest_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (digest_valid && !digest_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stall decided at the falling edge holds through the next rising edge
  task automatic send_item(input logic [7:0] data, input bit last, input bit none);
    md5_pkg::msg_req_t req;
    int gap;
    bit took;
    req.data_byte = data;
    req.last_byte = last;
    req.no_byte = none;
    gap = msg_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= req;
    do begin
      @(negedge clk);
      took = !msg_stall;
      @(posedge clk);
    end while (!took);
    if (!(none && !last)) item_total++;
  endtask

  task automatic send_message(input int len, input bit flag_end);
    int k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b1);
      send_item(8'($urandom), (k == len - 1) && !flag_end, 1'b0);
    end
    if (flag_end || len == 0) send_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    msg_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int len;
    bit drained_mid;
    rst = 1'b1;
    msg_valid = 1'b0;
    msg = '0;
    idle_cycles = 0;
    item_total = 0;
    msg_burst = 1'b0;
    drained_mid = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty message, single extreme bytes, "abc", ignored items, flag-ended message
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h7f, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h55, 1'b1, 1'b1);
    wait_drained();

    item_total = 0;
    while (item_total < RANDOM_ITEMS) begin
      msg_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) len = EDGE_LENGTHS[$urandom_range(0, 9)];
      else len = $urandom_range(0, 24);
      send_message(len, $urandom_range(0, 2) == 0);
      if (!drained_mid && item_total > RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
    end
    msg_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int wait_n;
    int got_n;
    bit took;
    digest_stall = 1'b0;
    digest_burst = 1'b0;
    got_n = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (got_n % 16 == 0) digest_burst = ($urandom_range(0, 3) == 0);
      wait_n = digest_burst ? 0 : $urandom_range(0, 6);
      if (wait_n > 0) begin
        digest_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        digest_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        took = digest_valid;
        @(posedge clk);
      end while (!took);
      got_n++;
    end
  end

endmodule

// ===== sim.f =====
rtl/md5_pkg.sv
rtl/md5_front.sv
rtl/md5_queue.sv
rtl/md5_back.sv
rtl/md5_emit.sv
rtl/md5_message_digest.sv
sim/md5_digest_checker.sv
sim/tb_md5_message_digest.sv
